// ===== hw/rtl/glmd_pkg.sv =====
// ----------------------------------------------------------------------------
// glmd_pkg
// Shared sizes and register codes for the grid local minimum detector.
// ----------------------------------------------------------------------------
package glmd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int SIZE_W   = 11;
  localparam int HEIGHT_W = 4;
  localparam int RISK_W   = 24;
  localparam int CFG_IDX_W = 1;

  localparam logic [RISK_W-1:0] RISK_MAX = {RISK_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // pending-result mask bits
  localparam int RES_ABOVE = 0;
  localparam int RES_LEFT  = 1;
  localparam int RES_LAST  = 2;
  localparam int RES_N     = 3;

endpackage

// ===== hw/rtl/grid_local_minimum_detector.sv =====
// ----------------------------------------------------------------------------
// grid_local_minimum_detector
// Four-neighbour low point detector over a raster stream of cell heights,
// built around two dual-read line store memories.
// ----------------------------------------------------------------------------
// A request is registered in the decision stage, its results in the output
// register. One request per cycle is taken while the output is not stalled;
// a last-row request deciding two or three cells holds the decision stage
// until it has emitted one result each. Reset clears counters, risk sum and
// pipeline and sets both frame sizes to 1024; line stores need no clearing.
module grid_local_minimum_detector (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [glmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [glmd_pkg::SIZE_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [glmd_pkg::HEIGHT_W-1:0]      height_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [glmd_pkg::ROW_W-1:0]         cell_row,
  output logic [glmd_pkg::COL_W-1:0]         cell_column,
  output logic                               is_low_point,
  output logic [glmd_pkg::RISK_W-1:0]        risk_sum,
  output logic                               frame_done
);
  import glmd_pkg::*;

  // configuration
  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;
  logic [SIZE_W-1:0] width_eff;
  logic [SIZE_W-1:0] height_eff;

  // input side
  logic [COL_W-1:0]  col_cnt;
  logic [ROW_W-1:0]  row_cnt;
  logic              accept;
  logic              last_col_in;
  logic              last_row_in;
  logic [COL_W-1:0]  c_in;
  logic [ROW_W-1:0]  r_in;
  logic [RES_N-1:0]  mask_in;
  logic [COL_W-1:0]  a_cp1;
  logic [COL_W-1:0]  a_cm1;

  // line stores
  logic [HEIGHT_W-1:0] prev_mem  [MAX_WIDTH];
  logic [HEIGHT_W-1:0] older_mem [MAX_WIDTH];
  logic [HEIGHT_W-1:0] prev_rd_c;
  logic [HEIGHT_W-1:0] prev_rd_cp1;
  logic [HEIGHT_W-1:0] older_rd_c;
  logic [HEIGHT_W-1:0] older_rd_cm1;
  logic                fwd_prev_c;
  logic                fwd_prev_cp1;
  logic                fwd_older_c;
  logic                fwd_older_cm1;
  logic [HEIGHT_W-1:0] fwd_prev_data;
  logic [HEIGHT_W-1:0] fwd_older_data;

  // decision stage
  logic                s1_valid;
  logic [HEIGHT_W-1:0] s1_value;
  logic [COL_W-1:0]    s1_col;
  logic [ROW_W-1:0]    s1_row;
  logic                s1_last_col;
  logic [RES_N-1:0]    s1_mask;
  logic [RES_N-1:0]    mask_rest;
  logic                emit;
  logic                retire;
  logic [HEIGHT_W-1:0] pc;
  logic [HEIGHT_W-1:0] pc1;
  logic [HEIGHT_W-1:0] oc;
  logic [HEIGHT_W-1:0] ocm1;
  logic [HEIGHT_W-1:0] rec0;
  logic [HEIGHT_W-1:0] rec1;
  logic                low_above;
  logic                low_left;
  logic                low_last;

  // selected result
  logic [ROW_W-1:0]    res_row;
  logic [COL_W-1:0]    res_col;
  logic [HEIGHT_W-1:0] res_centre;
  logic                res_low;
  logic                res_done;
  logic [RISK_W:0]     risk_wide;
  logic [RISK_W-1:0]   risk_next;
  logic [RISK_W-1:0]   risk_acc;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= SIZE_W'(MAX_WIDTH);
      frame_height <= SIZE_W'(MAX_HEIGHT);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (frame_width == '0)                        width_eff = SIZE_W'(1);
    else if (frame_width > SIZE_W'(MAX_WIDTH))    width_eff = SIZE_W'(MAX_WIDTH);
    else                                          width_eff = frame_width;
    if (frame_height == '0)                       height_eff = SIZE_W'(1);
    else if (frame_height > SIZE_W'(MAX_HEIGHT))  height_eff = SIZE_W'(MAX_HEIGHT);
    else                                          height_eff = frame_height;
  end

  // --------------------------------------------------------------------------
  // Position of the incoming request
  // --------------------------------------------------------------------------
  assign accept      = in_valid && in_ready;
  assign last_col_in = SIZE_W'(col_cnt) >= (width_eff - SIZE_W'(1));
  assign last_row_in = SIZE_W'(row_cnt) >= (height_eff - SIZE_W'(1));
  assign c_in        = last_col_in ? COL_W'(width_eff - SIZE_W'(1)) : col_cnt;
  assign r_in        = last_row_in ? ROW_W'(height_eff - SIZE_W'(1)) : row_cnt;
  assign a_cp1       = c_in + COL_W'(1);
  assign a_cm1       = c_in - COL_W'(1);

  always_comb begin
    mask_in            = '0;
    mask_in[RES_ABOVE] = (r_in != '0);
    mask_in[RES_LEFT]  = last_row_in && (c_in != '0);
    mask_in[RES_LAST]  = last_row_in && last_col_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (last_col_in) begin
        col_cnt <= '0;
        row_cnt <= last_row_in ? '0 : r_in + ROW_W'(1);
      end else begin
        col_cnt <= c_in + COL_W'(1);
        row_cnt <= r_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line stores: read on acceptance, written back when the request retires.
  // Forward the write-back when it lands on an address read at the same edge.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (retire) begin
      prev_mem[s1_col]  <= s1_value;
      older_mem[s1_col] <= pc;
    end
    if (accept) begin
      prev_rd_c    <= prev_mem[c_in];
      prev_rd_cp1  <= prev_mem[a_cp1];
      older_rd_c   <= older_mem[c_in];
      older_rd_cm1 <= older_mem[a_cm1];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_prev_c     <= retire && (c_in  == s1_col);
      fwd_prev_cp1   <= retire && (a_cp1 == s1_col);
      fwd_older_c    <= retire && (c_in  == s1_col);
      fwd_older_cm1  <= retire && (a_cm1 == s1_col);
      fwd_prev_data  <= s1_value;
      fwd_older_data <= pc;
    end
  end

  assign pc   = fwd_prev_c    ? fwd_prev_data  : prev_rd_c;
  assign pc1  = fwd_prev_cp1  ? fwd_prev_data  : prev_rd_cp1;
  assign oc   = fwd_older_c   ? fwd_older_data : older_rd_c;
  assign ocm1 = fwd_older_cm1 ? fwd_older_data : older_rd_cm1;

  // --------------------------------------------------------------------------
  // Decision stage: emit pending results lowest first, then retire
  // --------------------------------------------------------------------------
  assign mask_rest = s1_mask & (s1_mask - RES_N'(1));
  assign emit      = s1_valid && (s1_mask != '0) && (!out_valid || out_ready);
  assign retire    = s1_valid && ((emit ? mask_rest : s1_mask) == '0);
  assign in_ready  = !s1_valid || retire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_mask  <= '0;
    end else if (accept) begin
      s1_valid <= 1'b1;
      s1_mask  <= mask_in;
    end else begin
      if (retire) s1_valid <= 1'b0;
      if (emit)   s1_mask  <= mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value    <= height_value;
      s1_col      <= c_in;
      s1_row      <= r_in;
      s1_last_col <= last_col_in;
    end
  end

  // last two heights of the row, advanced as each request retires
  always_ff @(posedge clk) begin
    if (rst) begin
      rec0 <= '0;
      rec1 <= '0;
    end else if (retire) begin
      rec1 <= rec0;
      rec0 <= s1_value;
    end
  end

  // an absent neighbour never blocks a low point
  assign low_above = ((s1_row == ROW_W'(1)) || (pc < oc))
                  && ((s1_col == '0) || (pc < ocm1))
                  && (s1_last_col || (pc < pc1))
                  && (pc < s1_value);
  assign low_left  = ((s1_row == '0) || (rec0 < ocm1))
                  && ((s1_col == COL_W'(1)) || (rec0 < rec1))
                  && (rec0 < s1_value);
  assign low_last  = ((s1_row == '0) || (s1_value < pc))
                  && ((s1_col == '0) || (s1_value < rec0));

  always_comb begin
    if (s1_mask[RES_ABOVE]) begin
      res_row    = s1_row - ROW_W'(1);
      res_col    = s1_col;
      res_centre = pc;
      res_low    = low_above;
      res_done   = 1'b0;
    end else if (s1_mask[RES_LEFT]) begin
      res_row    = s1_row;
      res_col    = s1_col - COL_W'(1);
      res_centre = rec0;
      res_low    = low_left;
      res_done   = 1'b0;
    end else begin
      res_row    = s1_row;
      res_col    = s1_col;
      res_centre = s1_value;
      res_low    = low_last;
      res_done   = 1'b1;
    end
  end

  // saturating risk sum
  assign risk_wide = {1'b0, risk_acc}
                   + (res_low ? (RISK_W+1)'(res_centre) + (RISK_W+1)'(1) : '0);
  assign risk_next = risk_wide[RISK_W] ? RISK_MAX : risk_wide[RISK_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      risk_acc <= '0;
    end else if (emit) begin
      // clear at frame end so the next frame starts its own total
      risk_acc <= res_done ? '0 : risk_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cell_row     <= res_row;
      cell_column  <= res_col;
      is_low_point <= res_low;
      risk_sum     <= risk_next;
      frame_done   <= res_done;
    end
  end

endmodule

// ===== tb/glmd_low_point_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glmd_low_point_checker
// Watches the size, height and cell channels of the grid local minimum
// detector, works out every decided cell from the accepted heights and checks
// each reported cell against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module glmd_low_point_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [glmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [glmd_pkg::SIZE_W-1:0]    cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [glmd_pkg::HEIGHT_W-1:0]  height_value,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [glmd_pkg::ROW_W-1:0]     cell_row,
  input  logic [glmd_pkg::COL_W-1:0]     cell_column,
  input  logic                           is_low_point,
  input  logic [glmd_pkg::RISK_W-1:0]    risk_sum,
  input  logic                           frame_done,
  output int                             mismatches,
  output int                             pending,
  output int                             cells_decided,
  output int                             low_cells_seen,
  output int                             frames_closed
);
  import glmd_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              low;
    logic [RISK_W-1:0] risk;
    logic              done;
  } cell_verdict_t;

  cell_verdict_t expected_cells[$];

  logic [SIZE_W-1:0]   width_reg;
  logic [SIZE_W-1:0]   height_reg;
  logic [HEIGHT_W-1:0] row_above [MAX_WIDTH];
  logic [HEIGHT_W-1:0] row_older [MAX_WIDTH];
  logic [HEIGHT_W-1:0] recent [2];
  int unsigned         row_pos;
  int unsigned         col_pos;
  logic [RISK_W-1:0]   risk_total;

  function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] s, input int unsigned lim);
    if (s == 0)
      return 1;
    if (s > lim)
      return lim;
    return s;
  endfunction

  // an absent neighbour never stops a cell from being a low point
  function automatic bit beats(input logic [HEIGHT_W-1:0] centre, input bit present,
                               input logic [HEIGHT_W-1:0] nb);
    return !present || (centre < nb);
  endfunction

  function automatic void record_cell(input int unsigned row, input int unsigned col,
                                      input logic [HEIGHT_W-1:0] centre, input bit low,
                                      input bit done);
    cell_verdict_t verdict;
    int unsigned   sum;
    if (low) begin
      sum = int'(risk_total) + int'(centre) + 1;
      if (sum > RISK_MAX)
        sum = 32'(RISK_MAX);
      risk_total = sum[RISK_W-1:0];
    end
    verdict.row  = row[ROW_W-1:0];
    verdict.col  = col[COL_W-1:0];
    verdict.low  = low;
    verdict.risk = risk_total;
    verdict.done = done;
    expected_cells.insert(expected_cells.size(), verdict);
  endfunction

  function automatic void predict_cells(input logic [HEIGHT_W-1:0] v);
    int unsigned         w;
    int unsigned         h;
    int unsigned         c;
    int unsigned         r;
    bit                  last_col;
    bit                  last_row;
    bit                  low;
    logic [HEIGHT_W-1:0] centre;
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_HEIGHT);
    c = col_pos;
    r = row_pos;
    last_col = (c >= w - 1);
    last_row = (r >= h - 1);
    if (last_col)
      c = w - 1;
    if (last_row)
      r = h - 1;

    // the cell above is complete once the cell below it arrives
    if (r > 0) begin
      centre = row_above[c];
      low = beats(centre, r > 1, row_older[c])
         && beats(centre, c > 0, (c > 0) ? row_older[c - 1] : '0)
         && beats(centre, !last_col, !last_col ? row_above[c + 1] : '0)
         && beats(centre, 1'b1, v);
      record_cell(r - 1, c, centre, low, 1'b0);
    end

    row_older[c] = row_above[c];
    row_above[c] = v;

    // bottom row: the cell to the left, then the corner at the end of the row
    if (last_row) begin
      if (c > 0) begin
        centre = recent[0];
        low = beats(centre, r > 0, row_older[c - 1])
           && beats(centre, c > 1, recent[1])
           && beats(centre, 1'b1, v);
        record_cell(r, c - 1, centre, low, 1'b0);
      end
      if (last_col) begin
        low = beats(v, r > 0, row_older[c]) && beats(v, c > 0, recent[0]);
        record_cell(r, c, v, low, 1'b1);
      end
    end

    recent[1] = recent[0];
    recent[0] = v;

    if (last_col) begin
      col_pos = 0;
      if (last_row) begin
        row_pos    = 0;
        risk_total = '0;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    cell_verdict_t want;
    if (rst) begin
      width_reg      = SIZE_W'(MAX_WIDTH);
      height_reg     = SIZE_W'(MAX_HEIGHT);
      row_pos        = 0;
      col_pos        = 0;
      recent[0]      = '0;
      recent[1]      = '0;
      risk_total     = '0;
      mismatches     = 0;
      cells_decided  = 0;
      low_cells_seen = 0;
      frames_closed  = 0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_above[i] = '0;
        row_older[i] = '0;
      end
      expected_cells.delete();
    end else begin
      if (out_valid && out_ready) begin
        cells_decided++;
        if (expected_cells.size() == 0) begin
          $error("cell (%0d,%0d) reported while no cell was outstanding",
                 cell_row, cell_column);
          mismatches++;
        end else begin
          want = expected_cells.pop_front();
          check_field("cell_row", want.row, cell_row);
          check_field("cell_column", want.col, cell_column);
          check_field("is_low_point", want.low, is_low_point);
          check_field("risk_sum", want.risk, risk_sum);
          check_field("frame_done", want.done, frame_done);
          low_cells_seen += int'(want.low);
          frames_closed  += int'(want.done);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FRAME_WIDTH)
          width_reg = cfg_data;
        else if (cfg_index == REG_FRAME_HEIGHT)
          height_reg = cfg_data;
      end
      if (in_valid && in_ready)
        predict_cells(height_value);
    end
    pending <= expected_cells.size();
  end

endmodule

// ===== tb/tb_grid_local_minimum_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_local_minimum_detector
// Streams height grids of many sizes into the low point detector with random
// gaps and output stalls; a separate checker predicts and compares every cell.
// ----------------------------------------------------------------------------
module tb_grid_local_minimum_detector;
  import glmd_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 12;
  localparam int STALL_PCT      = 10;
  localparam int HOLD_OFF       = 6;
  localparam int QUIET_LIMIT    = 2000;
  localparam int RANDOM_HEIGHTS = 330;

  logic                 clk;
  logic                 rst          = 1'b1;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = REG_FRAME_WIDTH;
  logic [SIZE_W-1:0]    cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic [HEIGHT_W-1:0]  height_value = '0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic [ROW_W-1:0]     cell_row;
  logic [COL_W-1:0]     cell_column;
  logic                 is_low_point;
  logic [RISK_W-1:0]    risk_sum;
  logic                 frame_done;

  int mismatches;
  int pending;
  int cells_decided;
  int low_cells_seen;
  int frames_closed;
  int heights_sent = 0;
  int quiet_cycles = 0;
  bit steady       = 1'b0;

  // 3x3 grid: corner minimum, low centre, tied pair and a full-scale digit
  logic [HEIGHT_W-1:0] grid3 [9] = '{4'd0, 4'd5, 4'd5, 4'd5, 4'd2, 4'd5, 4'd9, 4'd9, 4'd15};

  grid_local_minimum_detector dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .height_value (height_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cell_row     (cell_row),
    .cell_column  (cell_column),
    .is_low_point (is_low_point),
    .risk_sum     (risk_sum),
    .frame_done   (frame_done)
  );

  glmd_low_point_checker scoreboard (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .height_value   (height_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cell_row       (cell_row),
    .cell_column    (cell_column),
    .is_low_point   (is_low_point),
    .risk_sum       (risk_sum),
    .frame_done     (frame_done),
    .mismatches     (mismatches),
    .pending        (pending),
    .cells_decided  (cells_decided),
    .low_cells_seen (low_cells_seen),
    .frames_closed  (frames_closed)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst)
      out_ready <= 1'b0;
    else
      out_ready <= steady || ($urandom_range(99) >= STALL_PCT);
  end

  // abort when no channel has moved a request for too long
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [HEIGHT_W-1:0] pick_height(input int span);
    logic [HEIGHT_W-1:0] v;
    if ($urandom_range(9) == 0)
      v = HEIGHT_W'($urandom_range(15, 10));
    else
      v = HEIGHT_W'($urandom_range(span, 0));
    return v;
  endfunction

  task automatic send_height(input logic [HEIGHT_W-1:0] v);
    while (!steady && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    height_value <= v;
    do @(posedge clk); while (!in_ready);
    heights_sent++;
  endtask

  // hold the sender until every outstanding cell is out, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_sizes(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_frame(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                           input int span);
    int cols;
    int rows;
    int pause_at;
    cols = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : int'(w);
    rows = (h == 0) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : int'(h);
    pause_at = ($urandom_range(3) == 0) ? int'($urandom_range(cols * rows - 1)) : -1;
    for (int i = 0; i < cols * rows; i++) begin
      if (i == pause_at && i > 0)
        drain();
      send_height(pick_height(span));
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] w_code;
    logic [SIZE_W-1:0] h_code;
    int                random_start;
    bit                resize;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // single-cell frames, back to back; a zero size acts as one
    write_sizes(1, 1);
    send_height(9);
    send_height(0);
    drain();
    write_sizes(0, 0);
    send_height(15);
    drain();

    // hold the stream mid-frame until the detector has caught up
    write_sizes(3, 3);
    for (int i = 0; i < 9; i++) begin
      if (i == 4)
        drain();
      send_height(grid3[i]);
    end
    drain();

    // single column and single row
    write_sizes(1, 3);
    send_height(4);
    send_height(2);
    send_height(7);
    drain();
    write_sizes(3, 1);
    send_height(15);
    send_height(0);
    send_height(15);

    // wide and tall frames, no idling on either side
    steady <= 1'b1;
    drain();
    write_sizes(40, 2);
    run_frame(40, 2, 9);
    drain();
    write_sizes(1, 40);
    run_frame(1, 40, 9);
    steady <= 1'b0;

    random_start = heights_sent;
    resize = 1'b1;
    w_code = 1;
    h_code = 1;
    while (heights_sent - random_start < RANDOM_HEIGHTS) begin
      if (resize || $urandom_range(1) == 0) begin
        w_code = ($urandom_range(9) == 0) ? SIZE_W'($urandom_range(40, 9))
                                          : SIZE_W'($urandom_range(8, 1));
        h_code = SIZE_W'($urandom_range(8, 1));
        if ($urandom_range(19) == 0)
          w_code = '0;
        if ($urandom_range(19) == 0)
          h_code = '0;
        drain();
        write_sizes(w_code, h_code);
        resize = 1'b0;
      end
      run_frame(w_code, h_code, ($urandom_range(3) == 0) ? 2 : 9);
    end

    drain();
    $display("Sent %0d heights; %0d frames closed with %0d cells decided, %0d low points.",
             heights_sent, frames_closed, cells_decided, low_cells_seen);
    $display("Sizes ran from a single cell up to 40 columns and 40 rows, zero codes included.");
    if (mismatches == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
